### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the UTF-8 stream decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside of reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition must never be true at a clock edge outside of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/core/u8dec_pkg.sv
// ----------------------------------------------------------------------------
// u8dec_pkg
// Types, byte-class constants and helpers shared by the UTF-8 decoder RTL.
// ----------------------------------------------------------------------------
package u8dec_pkg;

    localparam int unsigned CP_W   = 21;
    localparam int unsigned LEN_W  = 3;
    localparam int unsigned PEND_W = 2;
    localparam int unsigned BYTE_W = 8;

    // Lead byte ranges.
    localparam logic [BYTE_W-1:0] ASCII_MAX  = 8'h7F;
    localparam logic [BYTE_W-1:0] LEAD2_MIN  = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD2_MAX  = 8'hDF;
    localparam logic [BYTE_W-1:0] LEAD3_MIN  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_MAX  = 8'hEF;
    localparam logic [BYTE_W-1:0] LEAD4_MIN  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_MAX  = 8'hF4;

    // Continuation bytes have the form 10xxxxxx.
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG   = 8'h80;

    // Payload masks of the lead and continuation bytes.
    localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3F;
    localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_BITS = 8'h07;

    typedef enum logic [2:0] {
        LEAD_ONE,
        LEAD_TWO,
        LEAD_THREE,
        LEAD_FOUR,
        LEAD_BAD
    } lead_class_t;

    // Decoder state carried from one byte to the next.
    typedef struct packed {
        logic              halted;
        logic [PEND_W-1:0] pending;
        logic [LEN_W-1:0]  seq_len;
        logic [CP_W-1:0]   partial;
    } dec_state_t;

    // One result item.
    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] byte_length;
        logic             decode_error;
        logic             last_of_text;
    } dec_result_t;

    function automatic lead_class_t classify_lead(input logic [BYTE_W-1:0] b);
        lead_class_t c;
        if (b <= ASCII_MAX)
            c = LEAD_ONE;
        else if (b >= LEAD2_MIN && b <= LEAD2_MAX)
            c = LEAD_TWO;
        else if (b >= LEAD3_MIN && b <= LEAD3_MAX)
            c = LEAD_THREE;
        else if (b >= LEAD4_MIN && b <= LEAD4_MAX)
            c = LEAD_FOUR;
        else
            c = LEAD_BAD;
        return c;
    endfunction

endpackage

### rtl/core/u8dec_step.sv
// ----------------------------------------------------------------------------
// u8dec_step
// Combinational decode of one byte against the current decoder state.
// ----------------------------------------------------------------------------
module u8dec_step
    import u8dec_pkg::*;
(
    input  dec_state_t        state,
    input  logic [BYTE_W-1:0] text_byte,
    input  logic              end_of_text,
    output dec_state_t        state_next,
    output logic              emit,
    output dec_result_t       result
);

    lead_class_t       lead;
    logic [PEND_W-1:0] pend_dec;
    logic [CP_W-1:0]   shifted;
    logic              fail;

    assign lead     = classify_lead(text_byte);
    assign pend_dec = PEND_W'(state.pending - PEND_W'(1));
    assign shifted  = {state.partial[CP_W-7:0], text_byte[5:0] & CONT_BITS[5:0]};

    always_comb
    begin
        state_next = state;
        emit       = 1'b0;
        fail       = 1'b0;
        result     = '{code_point: '0, byte_length: '0, decode_error: 1'b0,
                       last_of_text: end_of_text};

        if (state.halted)
        begin
            if (end_of_text)
                state_next = '0;
        end
        else if (state.pending == '0)
        begin
            case (lead)
                LEAD_ONE:
                begin
                    state_next         = '0;
                    emit               = 1'b1;
                    result.code_point  = CP_W'(text_byte);
                    result.byte_length = LEN_W'(1);
                end
                LEAD_TWO:
                begin
                    state_next.partial = CP_W'(text_byte & LEAD2_BITS);
                    state_next.pending = PEND_W'(1);
                    state_next.seq_len = LEN_W'(2);
                    fail               = end_of_text;
                end
                LEAD_THREE:
                begin
                    state_next.partial = CP_W'(text_byte & LEAD3_BITS);
                    state_next.pending = PEND_W'(2);
                    state_next.seq_len = LEN_W'(3);
                    fail               = end_of_text;
                end
                LEAD_FOUR:
                begin
                    state_next.partial = CP_W'(text_byte & LEAD4_BITS);
                    state_next.pending = PEND_W'(3);
                    state_next.seq_len = LEN_W'(4);
                    fail               = end_of_text;
                end
                default:
                begin
                    fail = 1'b1;
                end
            endcase
        end
        else if ((text_byte & CONT_MASK) != CONT_TAG)
        begin
            fail = 1'b1;
        end
        else if (pend_dec == '0)
        begin
            state_next         = '0;
            emit               = 1'b1;
            result.code_point  = shifted;
            result.byte_length = state.seq_len;
        end
        else
        begin
            state_next.partial = shifted;
            state_next.pending = pend_dec;
            fail               = end_of_text;
        end

        // A malformed or truncated sequence gives one error result and
        // drops the rest of the text.
        if (fail)
        begin
            state_next          = '0;
            state_next.halted   = !end_of_text;
            emit                = 1'b1;
            result.code_point   = '0;
            result.byte_length  = '0;
            result.decode_error = 1'b1;
        end
    end

endmodule

### rtl/core/u8dec_skid.sv
// ----------------------------------------------------------------------------
// u8dec_skid
// Two-entry output buffer: a result register plus a skid register.
// ----------------------------------------------------------------------------
module u8dec_skid
    import u8dec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  dec_result_t push_data,
    output logic        space,
    output logic        out_valid,
    input  logic        out_ready,
    output dec_result_t out_data
);

`include "assert_macros.svh"

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    dec_result_t out_reg, out_next;
    dec_result_t skid_reg, skid_next;
    logic        pop;

    // The upstream side only stalls when both entries are full.
    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign pop       = out_valid_reg && out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;

        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = push_data;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    `ASSERT_NEVER(a_skid_without_out, clk, rst_n, skid_valid_reg && !out_valid_reg, "skid entry held while the result register is empty")
    `ASSERT_NEVER(a_push_when_full, clk, rst_n, push && skid_valid_reg, "result pushed while both entries are full")

endmodule

### rtl/core/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-serial UTF-8 decoder with stream interfaces on both sides.
// ----------------------------------------------------------------------------
//
//  Channel  | Dir | tdata                         | tuser        | tlast
//  ---------+-----+-------------------------------+--------------+-------------
//  s_axis   | in  | [7:0] text_byte               | -            | end_of_text
//  m_axis   | out | [20:0] code_point, [23:21] len| decode_error | last_of_text
//
//  One byte is accepted per cycle while the output buffer has room. The
//  byte and the decoder state feed a single level of decode logic whose
//  result is written into a two-entry output buffer that drives m_axis.
//  The state registers close the only loop, which is one short
//  compare-and-shift step, so back-to-back bytes are sustained.
//  s_axis_tready drops only when both output entries are full; a stalled
//  m_axis therefore costs throughput only after two results back up.
//  rst_n clears the decoder state and empties the output buffer at once.
//
module utf8_stream_decoder
    import u8dec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // end_of_text

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] byte_length
    output logic        m_axis_tuser,   // [0] decode_error
    output logic        m_axis_tlast    // last_of_text
);

`include "assert_macros.svh"

    dec_state_t  state_reg, state_next, step_state;
    dec_result_t step_result, out_result;
    logic        step_emit;
    logic        accept;
    logic        buf_space;

    assign s_axis_tready = buf_space;
    assign accept        = s_axis_tvalid && buf_space;

    // Decode of the current byte against the state left by earlier bytes.
    u8dec_step u_step (
        .state       (state_reg),
        .text_byte   (s_axis_tdata),
        .end_of_text (s_axis_tlast),
        .state_next  (step_state),
        .emit        (step_emit),
        .result      (step_result)
    );

    // The state only advances when a byte is actually taken.
    assign state_next = accept ? step_state : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else
            state_reg <= state_next;
    end

    // Output buffer decouples the result side from the byte side.
    u8dec_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && step_emit),
        .push_data (step_result),
        .space     (buf_space),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_result)
    );

    assign m_axis_tdata = {out_result.byte_length, out_result.code_point};
    assign m_axis_tuser = out_result.decode_error;
    assign m_axis_tlast = out_result.last_of_text;

    // The end of a text always leaves the decoder in its reset state.
    `ASSERT_PROP(a_eot_clears, clk, rst_n,
        accept && s_axis_tlast |=> state_reg == '0,
        "state not cleared after the last byte of a text")
    // While dropping bytes after an error, no sequence is in progress.
    `ASSERT_NEVER(a_halt_idle, clk, rst_n,
        state_reg.halted && (state_reg.pending != '0 || state_reg.partial != '0),
        "sequence state held while halted")
    // The recorded length always exceeds the bytes still outstanding.
    `ASSERT_NEVER(a_len_match, clk, rst_n,
        state_reg.pending != '0 && state_reg.seq_len <= LEN_W'(state_reg.pending),
        "sequence length out of step with pending count")

endmodule

### dv/tb_utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder
// Self-checking testbench for the byte-serial UTF-8 stream decoder. Text
// bytes go in on s_axis, and a decoding model inside the testbench predicts
// each character or error result. Results on m_axis are checked in order.
// Both sides idle at random, and the receiver also holds off for long spells.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    import u8dec_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned IDLE_PCT    = 13;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned TAIL_CYCLES = 8;

    // Directed bytes: bit 8 is end_of_text, bits 7:0 are the text byte.
    localparam int unsigned N_DIRECTED = 28;
    localparam logic [8:0] DIRECTED_BYTES [N_DIRECTED] = '{
        // Smallest character of each length, ending on the four-byte one.
        9'h000, 9'h0C2, 9'h080, 9'h0E0, 9'h080, 9'h080,
        9'h0F0, 9'h080, 9'h080, 9'h180,
        // Largest character of each length. F4 BF BF BF lies above 10FFFF.
        9'h07F, 9'h0DF, 9'h0BF, 9'h0EF, 9'h0BF, 9'h0BF,
        9'h0F4, 9'h0BF, 9'h0BF, 9'h1BF,
        // Bad lead byte, after which the rest of the text is dropped.
        9'h080, 9'h1FF,
        // Bad continuation byte. It must not be taken as a new lead byte.
        9'h0E2, 9'h0C0, 9'h141,
        // Text that ends right on a lead byte.
        9'h1C2,
        // Text that ends inside a four-byte sequence.
        9'h0F0, 9'h190
    };

    logic        clk;
    logic        rst_n;

    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] text_byte
    logic        s_axis_tlast;   // end_of_text

    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [20:0] code_point, [23:21] byte_length
    logic        m_axis_tuser;   // [0] decode_error
    logic        m_axis_tlast;   // last_of_text

    // Decoder state as the testbench sees it, and the results still owed.
    dec_state_t  text_state;
    dec_result_t char_queue [$];
    dec_result_t got_char;
    dec_result_t want_char;

    // Idling controls. rx_hold_cycles is counted down by the receiver.
    bit          tx_idle_on;
    bit          rx_idle_on;
    int unsigned rx_hold_cycles;

    int unsigned fail_count;
    int unsigned cycle_count;

    utf8_stream_decoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run guard. A hang anywhere ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding.",
                     cycle_count, char_queue.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Decodes one accepted byte and queues the result it causes, if any.
    // After an error the text is skipped until its last byte, and the last
    // byte of any text always leaves the decoder in its reset state.
    task automatic decode_byte(input logic [7:0] text_byte, input logic end_of_text);
        dec_result_t r;
        bit          emit;
        bit          broken;
        emit   = 1'b0;
        broken = 1'b0;
        r      = '0;
        r.last_of_text = end_of_text;
        if (text_state.halted)
        begin
            if (end_of_text)
                text_state = '0;
        end
        else if (text_state.pending == 0)
        begin
            if (text_state.pending == 0 && text_byte <= ASCII_MAX)
            begin
                r.code_point  = CP_W'(text_byte);
                r.byte_length = LEN_W'(1);
                emit          = 1'b1;
                text_state    = '0;
            end
            else if (text_byte >= LEAD2_MIN && text_byte <= LEAD2_MAX)
            begin
                text_state.partial = CP_W'(text_byte & LEAD2_BITS);
                text_state.pending = PEND_W'(1);
                text_state.seq_len = LEN_W'(2);
                broken             = end_of_text;
            end
            else if (text_byte >= LEAD3_MIN && text_byte <= LEAD3_MAX)
            begin
                text_state.partial = CP_W'(text_byte & LEAD3_BITS);
                text_state.pending = PEND_W'(2);
                text_state.seq_len = LEN_W'(3);
                broken             = end_of_text;
            end
            else if (text_byte >= LEAD4_MIN && text_byte <= LEAD4_MAX)
            begin
                text_state.partial = CP_W'(text_byte & LEAD4_BITS);
                text_state.pending = PEND_W'(3);
                text_state.seq_len = LEN_W'(4);
                broken             = end_of_text;
            end
            else
                broken = 1'b1;
        end
        else if ((text_byte & CONT_MASK) != CONT_TAG)
            broken = 1'b1;
        else
        begin
            text_state.partial = {text_state.partial[CP_W-7:0], text_byte[5:0]};
            text_state.pending = text_state.pending - 1'b1;
            if (text_state.pending == 0)
            begin
                r.code_point  = text_state.partial;
                r.byte_length = text_state.seq_len;
                emit          = 1'b1;
                text_state    = '0;
            end
            else
                broken = end_of_text;
        end
        // A malformed or truncated sequence gives one error result. Unless
        // the text ends here, the decoder then skips to the end of the text.
        if (broken)
        begin
            text_state        = '0;
            text_state.halted = !end_of_text;
            r.decode_error    = 1'b1;
            emit              = 1'b1;
        end
        if (emit)
            char_queue.push_back(r);
    endtask

    // Both interfaces are sampled at the rising edge, before any of the
    // edge's updates land, so accepted transactions are seen exactly once.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                decode_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_char = {m_axis_tdata[20:0], m_axis_tdata[23:21], m_axis_tuser,
                            m_axis_tlast};
                if (char_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: result with nothing outstanding: %s",
                                 $realtime,
                                 $sformatf("cp=%h len=%0d err=%b last=%b",
                                           got_char.code_point, got_char.byte_length,
                                           got_char.decode_error, got_char.last_of_text));
                end
                else
                begin
                    want_char = char_queue.pop_front();
                    if (got_char.code_point   !== want_char.code_point   ||
                        got_char.byte_length  !== want_char.byte_length  ||
                        got_char.decode_error !== want_char.decode_error ||
                        got_char.last_of_text !== want_char.last_of_text)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: mismatch (expected/actual): %s",
                                     $realtime,
                                     $sformatf("cp=%h/%h len=%0d/%0d err=%b/%b last=%b/%b",
                                               want_char.code_point, got_char.code_point,
                                               want_char.byte_length, got_char.byte_length,
                                               want_char.decode_error,
                                               got_char.decode_error,
                                               want_char.last_of_text,
                                               got_char.last_of_text));
                    end
                end
            end
        end
    end

    // Receiver. A requested hold-off keeps tready low until rx_hold_cycles has
    // counted down to zero; otherwise tready drops at random while idling is enabled.
    always @(posedge clk)
    begin
        if (rx_hold_cycles > 0)
        begin
            m_axis_tready  <= 1'b0;
            rx_hold_cycles <= rx_hold_cycles - 1;
        end
        else
            m_axis_tready <= !(rx_idle_on && $urandom_range(0, 99) < IDLE_PCT);
    end

    // Offers one byte and returns at the edge where the transaction completes.
    // tvalid stays high from one byte to the next unless an idle gap is drawn.
    task automatic send_byte(input logic [7:0] text_byte, input logic end_of_text);
        while (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= text_byte;
        s_axis_tlast  <= end_of_text;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Holds the sender until every predicted result has come back, then
    // waits out a tail for any byte still working through the block.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (char_queue.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Builds and sends one text. Most characters are well formed with random
    // payload; the rest are stray bytes, bad continuations or a sequence cut
    // short by the end of the text.
    task automatic send_random_text(output int unsigned sent);
        logic [7:0]  text_q [$];
        logic [7:0]  lead;
        int unsigned n_chars;
        int unsigned len;
        int unsigned sel;
        int unsigned good;
        bit          cut;
        cut     = 1'b0;
        n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
        for (int unsigned c = 0; c < n_chars && !cut; c++)
        begin
            len = $urandom_range(1, 4);
            case (len)
                1:       lead = 8'($urandom_range(0, ASCII_MAX));
                2:       lead = 8'($urandom_range(LEAD2_MIN, LEAD2_MAX));
                3:       lead = 8'($urandom_range(LEAD3_MIN, LEAD3_MAX));
                default: lead = 8'($urandom_range(LEAD4_MIN, LEAD4_MAX));
            endcase
            sel = $urandom_range(0, 99);
            if (sel < 8)
                text_q.push_back(8'($urandom_range(0, 255)));
            else
            begin
                text_q.push_back(lead);
                if (sel < 82)
                    repeat (len - 1) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
                else
                begin
                    good = (len > 1) ? $urandom_range(0, len - 2) : 0;
                    repeat (good) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
                    if (sel < 92)
                        text_q.push_back($urandom_range(0, 1) ?
                                         8'($urandom_range(8'h00, 8'h7F)) :
                                         8'($urandom_range(8'hC0, 8'hFF)));
                    else
                        cut = 1'b1;
                end
            end
        end
        foreach (text_q[i])
            send_byte(text_q[i], i == text_q.size() - 1);
        sent = text_q.size();
    endtask

    task automatic test_directed();
        for (int unsigned i = 0; i < N_DIRECTED; i++)
            send_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);
    endtask

    // The receiver stalls long enough for the output buffer to fill, while
    // the sender keeps offering ASCII, so the block has to stall its input.
    task automatic test_backpressure();
        wait_drained();
        rx_hold_cycles = 80;
        tx_idle_on     = 1'b0;
        for (int unsigned i = 0; i < 40; i++)
            send_byte(8'($urandom_range(0, ASCII_MAX)), i == 39);
        tx_idle_on = 1'b1;
    endtask

    // Back-to-back bytes with both sides always ready.
    task automatic test_no_idle(input int unsigned n_bytes);
        int unsigned sent;
        int unsigned total;
        total      = 0;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        while (total < n_bytes)
        begin
            send_random_text(sent);
            total += sent;
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Random texts with idling on both sides. Halfway through, the sender
    // pauses until everything it sent has been decoded.
    task automatic test_random(input int unsigned n_bytes);
        int unsigned sent;
        int unsigned total;
        bit          paused;
        total  = 0;
        paused = 1'b0;
        while (total < n_bytes)
        begin
            send_random_text(sent);
            total += sent;
            if (!paused && total >= n_bytes / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        s_axis_tlast   <= 1'b0;
        m_axis_tready  <= 1'b0;
        text_state     = '0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        rx_hold_cycles = 0;
        fail_count     = 0;
        cycle_count    = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_no_idle(150);
        test_random(740);

        wait_drained();
        if (fail_count == 0 && char_queue.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
